/* rtl/core/mjd_pkg.sv */
// ----------------------------------------------------------------------------
// mjd_pkg
// Shared types, constants and helpers for the multiserver job dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

package mjd_pkg;

    // Sizing
    localparam int NUM_CLASSES  = 4;
    localparam int QUEUE_DEPTH  = 64;
    localparam int MAX_RESULTS  = 64;
    localparam int CLS_W        = 2;
    localparam int ID_W         = 32;
    localparam int SRV_W        = 7;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int RES_W        = $clog2(MAX_RESULTS + 1);
    localparam int RAM_AW       = CLS_W + PTR_W;
    localparam int RAM_DEPTH    = NUM_CLASSES * QUEUE_DEPTH;
    localparam int CFG_IDX_W    = 3;
    localparam int IN_DATA_W    = 48;
    localparam int OUT_DATA_W   = 48;

    localparam logic [SRV_W-1:0] TOTAL_RESET = SRV_W'(64);
    localparam logic [SRV_W-1:0] SIZE_RESET  = SRV_W'(1);

    // Event kinds (tuser on the input side)
    localparam logic OP_ARRIVE = 1'b0;
    localparam logic OP_DEPART = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd4;

    // Result status (tuser on the output side)
    typedef enum logic [1:0] {
        STAT_DISPATCH = 2'd0,
        STAT_NONE     = 2'd1,
        STAT_DROP     = 2'd2
    } status_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // Live configuration
    typedef struct packed {
        logic [SRV_W-1:0]                  total;
        logic [NUM_CLASSES-1:0][SRV_W-1:0] size;
    } cfg_t;

    // Pool size write, seen by the controller to clamp the free count
    typedef struct packed {
        logic             wr;
        logic [SRV_W-1:0] total;
    } cfg_upd_t;

    // Job id memory request
    typedef struct packed {
        logic              we;
        logic [RAM_AW-1:0] waddr;
        logic [ID_W-1:0]   wdata;
        logic              re;
        logic [RAM_AW-1:0] raddr;
    } ram_req_t;

    // Input beat payload, last field in the low bits
    typedef struct packed {
        logic [6:0]       pad;
        logic [SRV_W-1:0] release_size;
        logic [ID_W-1:0]  job_id;
        logic [CLS_W-1:0] job_class;
    } in_beat_t;

    // Output beat payload, last field in the low bits
    typedef struct packed {
        logic [6:0]       pad;
        logic [SRV_W-1:0] free_after;
        logic [ID_W-1:0]  dispatch_id;
        logic [CLS_W-1:0] dispatch_class;
    } out_beat_t;

    // Circular queue pointer advance
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/multiserver_job_dispatcher.sv */
// ----------------------------------------------------------------------------
// multiserver_job_dispatcher
// Greedy multi-server dispatcher: per-class job FIFOs, shared server pool.
// ----------------------------------------------------------------------------
// One event is taken at a time. An arrival is queued in its class FIFO (or
// dropped with a single status beat if the FIFO is full); a departure returns
// servers to the pool. The classes are then scanned from the highest index
// down, and each job that fits the free servers is sent out as one beat.
// Each dispatched job passes through ST_SCAN, which issues the id read from
// the job id RAM, and then ST_EMIT, which loads the result register; an event
// that dispatches nothing also passes through both, a dropped arrival goes
// straight to ST_EMIT, and ST_EMIT waits while the last result beat is not yet
// taken on m_axis_tready. The final beat of every event carries tlast.
// Configuration should be written between events; the block does not enforce it.
`default_nettype none

module multiserver_job_dispatcher import mjd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [SRV_W-1:0]      cfg_data,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // job_class, job_id, release_size
    input  wire logic                  s_axis_tuser,   // opcode
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,   // dispatch_class, dispatch_id, free_after
    output      logic [1:0]            m_axis_tuser,   // status
    output      logic                  m_axis_tlast
);

    logic [SRV_W-1:0] total_reg;
    logic [SRV_W-1:0] size_reg [NUM_CLASSES];
    cfg_t             cfg;
    cfg_upd_t         cfg_upd;
    ram_req_t         ram_req;
    logic [ID_W-1:0]  ram_rdata;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= TOTAL_RESET;
            for (int k = 0; k < NUM_CLASSES; k++)
                size_reg[k] <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TOTAL: total_reg   <= cfg_data;
                REG_SIZE0: size_reg[0] <= cfg_data;
                REG_SIZE1: size_reg[1] <= cfg_data;
                REG_SIZE2: size_reg[2] <= cfg_data;
                REG_SIZE3: size_reg[3] <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_comb
    begin
        cfg.total = total_reg;
        for (int k = 0; k < NUM_CLASSES; k++)
            cfg.size[k] = size_reg[k];
        cfg_upd.wr    = cfg_we && (cfg_index == REG_TOTAL);
        cfg_upd.total = cfg_data;
    end

    // Event sequencer
    mjd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cfg_upd       (cfg_upd),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .ram_req       (ram_req),
        .ram_rdata     (ram_rdata)
    );

    // Job id storage, addressed by {class, queue slot}
    mjd_ram #(
        .WIDTH (ID_W),
        .DEPTH (RAM_DEPTH)
    ) u_id_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

/* rtl/core/mjd_ram.sv */
// ----------------------------------------------------------------------------
// mjd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mjd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rd_data_reg <= mem_reg[raddr];
    end

    assign rdata = rd_data_reg;

endmodule

`default_nettype wire

/* rtl/core/mjd_ctrl.sv */
// ----------------------------------------------------------------------------
// mjd_ctrl
// Event sequencer: queue bookkeeping, free pool, dispatch scan, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mjd_ctrl import mjd_pkg::*; (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cfg_t                  cfg,
    input  wire cfg_upd_t              cfg_upd,
    input  wire logic                  s_axis_tvalid,
    output      logic                  s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // job_class, job_id, release_size
    input  wire logic                  s_axis_tuser,   // opcode
    output      logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output      logic [OUT_DATA_W-1:0] m_axis_tdata,   // dispatch_class, dispatch_id, free_after
    output      logic [1:0]            m_axis_tuser,   // status
    output      logic                  m_axis_tlast,
    output      ram_req_t              ram_req,
    input  wire logic [ID_W-1:0]       ram_rdata
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0] wait_cnt_reg [NUM_CLASSES];
    logic [CNT_W-1:0] wait_cnt_next[NUM_CLASSES];
    logic [PTR_W-1:0] head_reg     [NUM_CLASSES];
    logic [PTR_W-1:0] head_next    [NUM_CLASSES];
    logic [PTR_W-1:0] tail_reg     [NUM_CLASSES];
    logic [PTR_W-1:0] tail_next    [NUM_CLASSES];
    logic [SRV_W-1:0] free_reg, free_next;
    logic [RES_W-1:0] nres_reg, nres_next;

    // Pending result, waiting for the id read and the output register
    status_t          pend_status_reg, pend_status_next;
    logic [CLS_W-1:0] pend_class_reg, pend_class_next;
    logic [SRV_W-1:0] pend_free_reg, pend_free_next;
    logic             pend_last_reg, pend_last_next;
    logic             pend_ram_reg, pend_ram_next;

    // Output register
    logic             m_valid_reg, m_valid_next;
    status_t          out_status_reg, out_status_next;
    logic [CLS_W-1:0] out_class_reg, out_class_next;
    logic [ID_W-1:0]  out_id_reg, out_id_next;
    logic [SRV_W-1:0] out_free_reg, out_free_next;
    logic             out_last_reg, out_last_next;

    in_beat_t         in_beat;
    out_beat_t        out_beat;
    logic             accept;
    logic             in_full;
    logic             out_room;
    logic             load_out;
    logic [SRV_W:0]   dep_sum;

    logic [NUM_CLASSES-1:0] elig;
    logic [NUM_CLASSES-1:0] next_elig;
    logic                   any_elig;
    logic [CLS_W-1:0]       pick_cls;
    logic [SRV_W-1:0]       pick_free;
    logic                   can_go;
    logic                   more;

    // Input decode
    assign in_beat  = in_beat_t'(s_axis_tdata);
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign in_full  = wait_cnt_reg[in_beat.job_class] >= CNT_W'(QUEUE_DEPTH);
    assign out_room = !m_valid_reg || m_axis_tready;
    assign dep_sum  = {1'b0, free_reg} + {1'b0, in_beat.release_size};

    // Eligible classes; the highest one is the next in scan order, since
    // free servers and queue counts only shrink during a scan
    always_comb
    begin
        any_elig = 1'b0;
        pick_cls = '0;
        for (int i = 0; i < NUM_CLASSES; i++)
        begin
            elig[i] = (free_reg != '0) && (wait_cnt_reg[i] != '0)
                      && (cfg.size[i] <= free_reg);
            if (elig[i])
            begin
                any_elig = 1'b1;
                pick_cls = CLS_W'(i);
            end
        end
    end

    // Look ahead past the dispatch being issued to mark the final result
    assign pick_free = free_reg - cfg.size[pick_cls];

    always_comb
    begin
        for (int j = 0; j < NUM_CLASSES; j++)
        begin
            next_elig[j] = (pick_free != '0) && (cfg.size[j] <= pick_free)
                           && ((CLS_W'(j) == pick_cls) ? (wait_cnt_reg[j] > CNT_W'(1))
                                                        : (wait_cnt_reg[j] != '0));
        end
    end

    assign can_go = any_elig && (nres_reg < RES_W'(MAX_RESULTS));
    assign more   = (|next_elig) && (nres_reg < RES_W'(MAX_RESULTS - 1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == OP_ARRIVE && in_full)
                        state_next = ST_EMIT;
                    else
                        state_next = ST_SCAN;
                end
            end
            ST_SCAN:
                state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_room)
                    state_next = pend_last_reg ? ST_IDLE : ST_SCAN;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Handshake and strobes
    always_comb
    begin
        s_axis_tready = (state_reg == ST_IDLE);
        load_out      = (state_reg == ST_EMIT) && out_room;
    end

    // Datapath next values
    always_comb
    begin
        wait_cnt_next    = wait_cnt_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        free_next        = free_reg;
        nres_next        = nres_reg;
        pend_status_next = pend_status_reg;
        pend_class_next  = pend_class_reg;
        pend_free_next   = pend_free_reg;
        pend_last_next   = pend_last_reg;
        pend_ram_next    = pend_ram_reg;
        ram_req          = '0;

        // Pool size write clamps the free count
        if (cfg_upd.wr && free_reg > cfg_upd.total)
            free_next = cfg_upd.total;

        if (accept)
        begin
            nres_next = '0;
            if (s_axis_tuser == OP_ARRIVE)
            begin
                if (in_full)
                begin
                    pend_status_next = STAT_DROP;
                    pend_class_next  = '0;
                    pend_free_next   = free_reg;
                    pend_last_next   = 1'b1;
                    pend_ram_next    = 1'b0;
                end
                else
                begin
                    // Enqueue at the tail; the scan reads no earlier than next cycle
                    ram_req.we    = 1'b1;
                    ram_req.waddr = {in_beat.job_class, tail_reg[in_beat.job_class]};
                    ram_req.wdata = in_beat.job_id;
                    tail_next[in_beat.job_class] = ptr_inc(tail_reg[in_beat.job_class]);
                    wait_cnt_next[in_beat.job_class] =
                        wait_cnt_reg[in_beat.job_class] + 1'b1;
                end
            end
            else
            begin
                // Departure: return servers, saturating at the pool size
                if (dep_sum > {1'b0, cfg.total})
                    free_next = cfg.total;
                else
                    free_next = dep_sum[SRV_W-1:0];
            end
        end

        if (state_reg == ST_SCAN)
        begin
            if (can_go)
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = {pick_cls, head_reg[pick_cls]};
                head_next[pick_cls]     = ptr_inc(head_reg[pick_cls]);
                wait_cnt_next[pick_cls] = wait_cnt_reg[pick_cls] - 1'b1;
                free_next        = pick_free;
                nres_next        = nres_reg + 1'b1;
                pend_status_next = STAT_DISPATCH;
                pend_class_next  = pick_cls;
                pend_free_next   = pick_free;
                pend_last_next   = !more;
                pend_ram_next    = 1'b1;
            end
            else
            begin
                pend_status_next = STAT_NONE;
                pend_class_next  = '0;
                pend_free_next   = free_reg;
                pend_last_next   = 1'b1;
                pend_ram_next    = 1'b0;
            end
        end
    end

    // Output register
    always_comb
    begin
        m_valid_next    = m_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_class_next  = out_class_reg;
        out_id_next     = out_id_reg;
        out_free_next   = out_free_reg;
        out_last_next   = out_last_reg;
        if (load_out)
        begin
            m_valid_next    = 1'b1;
            out_status_next = pend_status_reg;
            out_class_next  = pend_class_reg;
            out_id_next     = pend_ram_reg ? ram_rdata : '0;
            out_free_next   = pend_free_reg;
            out_last_next   = pend_last_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            free_reg    <= TOTAL_RESET;
            nres_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                wait_cnt_reg[k] <= '0;
                head_reg[k]     <= '0;
                tail_reg[k]     <= '0;
            end
        end
        else
        begin
            state_reg    <= state_next;
            free_reg     <= free_next;
            nres_reg     <= nres_next;
            m_valid_reg  <= m_valid_next;
            wait_cnt_reg <= wait_cnt_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_class_reg  <= pend_class_next;
        pend_free_reg   <= pend_free_next;
        pend_last_reg   <= pend_last_next;
        pend_ram_reg    <= pend_ram_next;
        out_status_reg  <= out_status_next;
        out_class_reg   <= out_class_next;
        out_id_reg      <= out_id_next;
        out_free_reg    <= out_free_next;
        out_last_reg    <= out_last_next;
    end

    // Output ports
    always_comb
    begin
        out_beat                = '0;
        out_beat.dispatch_class = out_class_reg;
        out_beat.dispatch_id    = out_id_reg;
        out_beat.free_after     = out_free_reg;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_DATA_W'(out_beat);
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;

    // Checks
    a_free_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= cfg.total)
        else $error("free count above pool size");

    a_nres_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nres_reg <= RES_W'(MAX_RESULTS))
        else $error("too many dispatches in one event");

    a_scan_lookahead: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && nres_reg != '0) |-> any_elig)
        else $error("scan resumed with nothing eligible");

    a_last_ends_event: assert property (@(posedge clk) disable iff (!rst_n)
        (load_out && pend_last_reg) |=> (state_reg == ST_IDLE))
        else $error("final result did not end the event");

    for (genvar g = 0; g < NUM_CLASSES; g++)
    begin : g_cnt_chk
        a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
            wait_cnt_reg[g] <= CNT_W'(QUEUE_DEPTH))
            else $error("queue count above depth");
    end

endmodule

`default_nettype wire
